[rtl/core/srp_pkg.sv]
package srp_pkg;

  localparam int unsigned POS_W   = 48;
  localparam int unsigned MAG_W   = 48;
  localparam int unsigned MASS_W  = 40;
  localparam int unsigned AREA_W  = 32;
  localparam int unsigned COEF_W  = 18;
  localparam int unsigned RAD_W   = 32;
  localparam int unsigned PRES_W  = 32;
  localparam int unsigned AU_W    = 40;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_EC_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_EC_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_EC_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_RAD  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PRES = 3'd4;
  localparam logic [IDX_W-1:0] REG_AU   = 3'd5;

  localparam logic [RAD_W-1:0]  RAD_RESET  = 32'd6371000;
  localparam logic [PRES_W-1:0] PRES_RESET = 32'd1283525894;
  localparam logic [AU_W-1:0]   AU_RESET   = 40'd149597870700;

  localparam logic [ACC_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_SUNLIT = 2'd0,
    ST_SHADOW = 2'd1,
    ST_CLOSE  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [POS_W-1:0] sat_x;
    logic signed [POS_W-1:0] sat_y;
    logic signed [POS_W-1:0] sat_z;
    logic signed [POS_W-1:0] sun_x;
    logic signed [POS_W-1:0] sun_y;
    logic signed [POS_W-1:0] sun_z;
    logic [MASS_W-1:0]       mass_kg;
    logic [AREA_W-1:0]       reflect_area;
    logic [COEF_W-1:0]       reflect_coeff;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    status_e                 status;
  } out_t;

  // Latency of srp_mul for a first operand of the given width.
  function automatic int unsigned mul_lat(input int unsigned wa);
    return 2 + ((wa + 31) >> 5);
  endfunction

endpackage

[rtl/core/solar_radiation_pressure_accel.sv]
// Solar radiation pressure acceleration, cannonball model with a cylindrical
// Earth shadow. A transaction is taken on every cycle in which start is high;
// busy never rises, so one item per clock is sustained. Each result appears on
// result_o with done_o high for exactly one cycle, in order; the receiver
// cannot stall it. The latency is set mostly by the 65-step square root of
// the sun distance, feeding the denominator multiply, and the 64-step
// quotient pipeline that follows. Configuration writes take effect at once
// and are meant to happen while no transaction is in flight.
module solar_radiation_pressure_accel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  srp_pkg::in_t                item_i,
  output logic                        done_o,
  output srp_pkg::out_t               result_o,
  input  logic                        cfg_we_i,
  input  logic [srp_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [srp_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned RW   = 65;
  localparam int unsigned QW   = srp_pkg::ACC_W;
  localparam int unsigned L48  = srp_pkg::mul_lat(48);
  localparam int unsigned L32  = srp_pkg::mul_lat(32);
  localparam int unsigned L18  = srp_pkg::mul_lat(18);
  localparam int unsigned L40  = srp_pkg::mul_lat(40);
  localparam int unsigned L64  = srp_pkg::mul_lat(64);
  localparam int unsigned L65  = srp_pkg::mul_lat(RW);
  localparam int unsigned L98  = srp_pkg::mul_lat(98);
  localparam int unsigned TQ   = L48 + 1;
  localparam int unsigned TSH  = TQ + L98 + 2;
  localparam int unsigned TB   = L32 + L18 + L40 + L40;
  localparam int unsigned TN   = TB + L48;
  localparam int unsigned TD   = TQ + RW + L65;
  localparam int unsigned TE   = TD + QW + 1;

  // Configuration registers.
  logic signed [srp_pkg::POS_W-1:0] ec_q [3];
  logic [srp_pkg::RAD_W-1:0]        rad_q;
  logic [srp_pkg::PRES_W-1:0]       pres_q;
  logic [srp_pkg::AU_W-1:0]         au_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q[0] <= '0;
      ec_q[1] <= '0;
      ec_q[2] <= '0;
      rad_q   <= srp_pkg::RAD_RESET;
      pres_q  <= srp_pkg::PRES_RESET;
      au_q    <= srp_pkg::AU_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srp_pkg::REG_EC_X: ec_q[0] <= cfg_wdata_i;
        srp_pkg::REG_EC_Y: ec_q[1] <= cfg_wdata_i;
        srp_pkg::REG_EC_Z: ec_q[2] <= cfg_wdata_i;
        srp_pkg::REG_RAD:  rad_q   <= cfg_wdata_i[srp_pkg::RAD_W-1:0];
        srp_pkg::REG_PRES: pres_q  <= cfg_wdata_i[srp_pkg::PRES_W-1:0];
        srp_pkg::REG_AU:   au_q    <= cfg_wdata_i[srp_pkg::AU_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic           acc_in;
  logic [TE:0]    vld_q;
  logic           done_q;

  assign acc_in = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[TE-1:0], acc_in};
      done_q <= vld_q[TE];
    end
  end

  // Input stage: sun and Earth offsets as magnitudes and signs.
  logic signed [srp_pkg::POS_W-1:0] sat_c [3];
  logic signed [srp_pkg::POS_W-1:0] sun_c [3];
  logic signed [srp_pkg::POS_W:0]   t_c [3];
  logic signed [srp_pkg::POS_W:0]   d_c [3];
  logic [2:0][srp_pkg::MAG_W-1:0]   tm_d;
  logic [2:0][srp_pkg::MAG_W-1:0]   dm_d;
  logic [2:0][srp_pkg::MAG_W-1:0]   tm_q;
  logic [2:0][srp_pkg::MAG_W-1:0]   dm_q;
  logic [2:0]                       tneg_q;
  logic [2:0]                       psgn_q;
  logic                             zero_q;
  logic [srp_pkg::MASS_W-1:0]       m_q;
  logic [srp_pkg::AREA_W-1:0]       a_q;
  logic [srp_pkg::COEF_W-1:0]       c_q;

  always_comb begin
    sat_c[0] = item_i.sat_x;
    sat_c[1] = item_i.sat_y;
    sat_c[2] = item_i.sat_z;
    sun_c[0] = item_i.sun_x;
    sun_c[1] = item_i.sun_y;
    sun_c[2] = item_i.sun_z;
    for (int i = 0; i < 3; i++) begin
      t_c[i]  = $signed({sun_c[i][srp_pkg::POS_W-1], sun_c[i]})
              - $signed({sat_c[i][srp_pkg::POS_W-1], sat_c[i]});
      d_c[i]  = $signed({sat_c[i][srp_pkg::POS_W-1], sat_c[i]})
              - $signed({ec_q[i][srp_pkg::POS_W-1], ec_q[i]});
      tm_d[i] = t_c[i][srp_pkg::POS_W] ? srp_pkg::MAG_W'(-t_c[i])
                                       : t_c[i][srp_pkg::MAG_W-1:0];
      dm_d[i] = d_c[i][srp_pkg::POS_W] ? srp_pkg::MAG_W'(-d_c[i])
                                       : d_c[i][srp_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    tm_q   <= tm_d;
    dm_q   <= dm_d;
    for (int i = 0; i < 3; i++) begin
      tneg_q[i] <= t_c[i][srp_pkg::POS_W];
      psgn_q[i] <= t_c[i][srp_pkg::POS_W] ^ d_c[i][srp_pkg::POS_W];
    end
    zero_q <= (t_c[0] == '0) && (t_c[1] == '0) && (t_c[2] == '0);
    m_q    <= item_i.mass_kg;
    a_q    <= item_i.reflect_area;
    c_q    <= item_i.reflect_coeff;
  end

  // Squares and cross products of the offsets.
  logic [2:0][95:0] tt_p;
  logic [2:0][95:0] dd_p;
  logic [2:0][95:0] td_p;
  logic [2:0]       psgn_d;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    srp_mul #(.WA(48), .WB(48)) u_tt (.clk_i, .a_i(tm_q[i]), .b_i(tm_q[i]), .p_o(tt_p[i]));
    srp_mul #(.WA(48), .WB(48)) u_dd (.clk_i, .a_i(dm_q[i]), .b_i(dm_q[i]), .p_o(dd_p[i]));
    srp_mul #(.WA(48), .WB(48)) u_td (.clk_i, .a_i(tm_q[i]), .b_i(dm_q[i]), .p_o(td_p[i]));
  end

  srp_dly #(.W(3), .N(L48)) u_psgn_dly (.clk_i, .d_i(psgn_q), .q_o(psgn_d));

  logic signed [98:0] dterm [3];
  logic signed [98:0] dot_c;
  logic [97:0]        q_q;
  logic [97:0]        dsq_q;
  logic [97:0]        dabs_q;
  logic               dneg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dterm[i] = psgn_d[i] ? -$signed({3'b000, td_p[i]}) : $signed({3'b000, td_p[i]});
    end
    dot_c = dterm[0] + dterm[1] + dterm[2];
  end

  always_ff @(posedge clk_i) begin
    q_q    <= 98'(tt_p[0]) + 98'(tt_p[1]) + 98'(tt_p[2]);
    dsq_q  <= 98'(dd_p[0]) + 98'(dd_p[1]) + 98'(dd_p[2]);
    dneg_q <= dot_c[98];
    dabs_q <= dot_c[98] ? 98'(-dot_c) : dot_c[97:0];
  end

  // Shadow test: on the far side of Earth and inside the shadow cylinder.
  logic [195:0] lhs_p;
  logic [195:0] dot2_p;
  logic [63:0]  r2_p;
  logic [161:0] r2q_p;
  logic [161:0] r2q_d;
  logic         dneg_d;
  logic [195:0] lhs_q;
  logic [196:0] rhs_q;
  logic         dneg2_q;
  logic         shadow_q;
  logic         shadow_e;

  srp_mul #(.WA(98), .WB(98)) u_lhs  (.clk_i, .a_i(dsq_q), .b_i(q_q), .p_o(lhs_p));
  srp_mul #(.WA(98), .WB(98)) u_dot2 (.clk_i, .a_i(dabs_q), .b_i(dabs_q), .p_o(dot2_p));
  srp_mul #(.WA(32), .WB(32)) u_r2   (.clk_i, .a_i(rad_q), .b_i(rad_q), .p_o(r2_p));
  srp_mul #(.WA(64), .WB(98)) u_r2q  (.clk_i, .a_i(r2_p), .b_i(q_q), .p_o(r2q_p));

  srp_dly #(.W(162), .N(L98 - L64)) u_r2q_dly (.clk_i, .d_i(r2q_p), .q_o(r2q_d));
  srp_dly #(.W(1), .N(L98)) u_dneg_dly (.clk_i, .d_i(dneg_q), .q_o(dneg_d));

  always_ff @(posedge clk_i) begin
    lhs_q    <= lhs_p;
    rhs_q    <= 197'(r2q_d) + 197'(dot2_p);
    dneg2_q  <= dneg_d;
    shadow_q <= dneg2_q && (197'(lhs_q) < rhs_q);
  end

  srp_dly #(.W(1), .N(TE - TSH)) u_shadow_dly (.clk_i, .d_i(shadow_q), .q_o(shadow_e));

  // Denominator: mass times squared distance times distance.
  logic [RW-1:0]  rr;
  logic [39:0]    m_d;
  logic [137:0]   mq_p;
  logic [137:0]   mq_d;
  logic [202:0]   den_p;

  srp_sqrt #(.RW(RW)) u_sqrt (.clk_i, .x_i({q_q, 32'd0}), .root_o(rr));

  srp_dly #(.W(40), .N(TQ)) u_m_dly (.clk_i, .d_i(m_q), .q_o(m_d));
  srp_mul #(.WA(40), .WB(98)) u_mq (.clk_i, .a_i(m_d), .b_i(q_q), .p_o(mq_p));
  srp_dly #(.W(138), .N(RW - L40)) u_mq_dly (.clk_i, .d_i(mq_p), .q_o(mq_d));
  srp_mul #(.WA(RW), .WB(138)) u_den (.clk_i, .a_i(rr), .b_i(mq_d), .p_o(den_p));

  // Numerators: pressure, area, coefficient and AU squared, times each offset.
  logic [63:0]              pa_p;
  logic [17:0]              c_d;
  logic [81:0]              pac_p;
  logic [121:0]             pacu_p;
  logic [161:0]             base_p;
  logic [2:0][47:0]         tm_b;
  logic [2:0][209:0]        num_p;
  logic [2:0][209:0]        num_d;
  logic [2:0][221:0]        num_c;
  logic [2:0]               nz_c;
  logic [2:0]               nz_e;
  logic [2:0]               tneg_e;
  logic                     zero_e;

  srp_mul #(.WA(32), .WB(32))  u_pa   (.clk_i, .a_i(pres_q), .b_i(a_q), .p_o(pa_p));
  srp_dly #(.W(18), .N(L32))   u_c_dly (.clk_i, .d_i(c_q), .q_o(c_d));
  srp_mul #(.WA(18), .WB(64))  u_pac  (.clk_i, .a_i(c_d), .b_i(pa_p), .p_o(pac_p));
  srp_mul #(.WA(40), .WB(82))  u_au1  (.clk_i, .a_i(au_q), .b_i(pac_p), .p_o(pacu_p));
  srp_mul #(.WA(40), .WB(122)) u_au2  (.clk_i, .a_i(au_q), .b_i(pacu_p), .p_o(base_p));
  srp_dly #(.W(144), .N(TB))   u_tm_dly (.clk_i, .d_i(tm_q), .q_o(tm_b));

  for (genvar i = 0; i < 3; i++) begin : g_num
    srp_mul #(.WA(48), .WB(162)) u_num (.clk_i, .a_i(tm_b[i]), .b_i(base_p), .p_o(num_p[i]));
  end

  srp_dly #(.W(630), .N(TD - TN)) u_num_dly (.clk_i, .d_i(num_p), .q_o(num_d));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = {num_d[i], 12'd0};
      nz_c[i]  = |num_d[i];
    end
  end

  logic [2:0][QW-1:0] quo;
  logic [2:0]         ovf;

  srp_div #(.NW(222), .DW(203), .QW(QW)) u_div (
    .clk_i,
    .num_i (num_c),
    .den_i (den_p),
    .quo_o (quo),
    .ovf_o (ovf)
  );

  srp_dly #(.W(3), .N(QW + 1)) u_nz_dly   (.clk_i, .d_i(nz_c), .q_o(nz_e));
  srp_dly #(.W(3), .N(TE))     u_tneg_dly (.clk_i, .d_i(tneg_q), .q_o(tneg_e));
  srp_dly #(.W(1), .N(TE))     u_zero_dly (.clk_i, .d_i(zero_q), .q_o(zero_e));

  // Output stage: saturate, apply the sign and pick the status.
  logic [QW-1:0] acc_c [3];
  logic [QW-1:0] mag;
  srp_pkg::out_t res_d;
  srp_pkg::out_t res_q;

  always_comb begin
    mag = '0;
    for (int i = 0; i < 3; i++) begin
      if (!nz_e[i]) begin
        acc_c[i] = '0;
      end else if (tneg_e[i]) begin
        mag      = (ovf[i] || (quo[i] > srp_pkg::SAT_NEG)) ? srp_pkg::SAT_NEG : quo[i];
        acc_c[i] = -mag;
      end else begin
        acc_c[i] = (ovf[i] || quo[i][QW-1]) ? srp_pkg::SAT_POS : quo[i];
      end
    end
    res_d.accel_x = acc_c[0];
    res_d.accel_y = acc_c[1];
    res_d.accel_z = acc_c[2];
    res_d.status  = srp_pkg::ST_SUNLIT;
    if (zero_e) begin
      res_d.accel_x = '0;
      res_d.accel_y = '0;
      res_d.accel_z = '0;
      res_d.status  = srp_pkg::ST_CLOSE;
    end else if (shadow_e) begin
      res_d.accel_x = '0;
      res_d.accel_y = '0;
      res_d.accel_z = '0;
      res_d.status  = srp_pkg::ST_SHADOW;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[rtl/core/srp_mul.sv]
module srp_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic               clk_i,
  input  logic [WA-1:0]      a_i,
  input  logic [WB-1:0]      b_i,
  output logic [WA+WB-1:0]   p_o
);

  localparam int unsigned NA   = (WA + 31) / 32;
  localparam int unsigned NB   = (WB + 31) / 32;
  localparam int unsigned WR   = 32 * (NB + 1);
  localparam int unsigned WACC = 32 * (NA + NB);

  logic [NA*32-1:0] a_ext;
  logic [NB*32-1:0] b_ext;
  logic [63:0]      pp_q [NA][NB];
  logic [WR-1:0]    row_d [NA];
  logic [WR-1:0]    row_q [NA];
  logic [WR-1:0]    rp_q [NA][NA];
  logic [WACC-1:0]  acc_q [NA];

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
  end

  // Even products in a row never overlap, nor do odd ones, so each row is one add.
  always_comb begin
    logic [WR-1:0] ev;
    logic [WR-1:0] od;
    for (int i = 0; i < NA; i++) begin
      ev = '0;
      od = '0;
      for (int j = 0; j < NB; j++) begin
        if (j % 2 == 0) begin
          ev[32*j +: 64] = pp_q[i][j];
        end else begin
          od[32*j +: 64] = pp_q[i][j];
        end
      end
      row_d[i] = ev + od;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  for (genvar k = 0; k < NA; k++) begin : g_acc
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        acc_q[0] <= WACC'(row_q[0]);
        rp_q[0]  <= row_q;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        acc_q[k] <= acc_q[k-1] + (WACC'(rp_q[k-1][k]) << (32 * k));
        rp_q[k]  <= rp_q[k-1];
      end
    end
  end

  assign p_o = acc_q[NA-1][WA+WB-1:0];

endmodule

[rtl/core/srp_dly.sv]
module srp_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

[rtl/core/srp_sqrt.sv]
module srp_sqrt #(
  parameter int unsigned RW = 65
) (
  input  logic              clk_i,
  input  logic [2*RW-1:0]   x_i,
  output logic [RW-1:0]     root_o
);

  localparam int unsigned XW = 2 * RW + 1;

  logic [XW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  // One result bit per stage, most significant first; rem holds x - root^2.
  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int unsigned N = RW - 1 - s;
    logic [XW-1:0] rem_in;
    logic [XW-1:0] term;
    logic [RW-1:0] root_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = XW'(x_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign term = (XW'(root_in) << (N + 1)) | (XW'(1) << (2 * N));
    assign ge   = rem_in >= term;

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? rem_in - term : rem_in;
      root_q[s] <= ge ? (root_in | (RW'(1) << N)) : root_in;
    end
  end

  assign root_o = root_q[RW-1];

endmodule

[rtl/core/srp_div.sv]
module srp_div #(
  parameter int unsigned NW = 222,
  parameter int unsigned DW = 203,
  parameter int unsigned QW = 64
) (
  input  logic                  clk_i,
  input  logic [2:0][NW-1:0]    num_i,
  input  logic [DW-1:0]         den_i,
  output logic [2:0][QW-1:0]    quo_o,
  output logic [2:0]            ovf_o
);

  localparam int unsigned WW = DW + QW;

  logic [2:0][WW-1:0] rem_q [QW+1];
  logic [DW-1:0]      den_q [QW+1];
  logic [2:0][QW-1:0] quo_q [QW+1];
  logic [2:0]         ovf_q [QW+1];

  // A quotient that does not fit in QW bits, including a zero divisor, is flagged here.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      rem_q[0][l] <= WW'(num_i[l]);
      ovf_q[0][l] <= WW'(num_i[l]) >= (WW'(den_i) << QW);
    end
    den_q[0] <= den_i;
    quo_q[0] <= '0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int unsigned B = QW - k;
    logic [WW-1:0] sh;
    logic [2:0]    ge;

    assign sh = WW'(den_q[k-1]) << B;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = rem_q[k-1][l] >= sh;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[k][l] <= ge[l] ? rem_q[k-1][l] - sh : rem_q[k-1][l];
        quo_q[k][l] <= quo_q[k-1][l] | (QW'(ge[l]) << B);
      end
      ovf_q[k] <= ovf_q[k-1];
      den_q[k] <= den_q[k-1];
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule
